### rtl/core/lrfp_pkg.sv
// Package: frame constants, status codes and digit weights of the rangefinder frame parser.
package lrfp_pkg;

  localparam int unsigned FrameLen  = 11;
  localparam int unsigned CheckPos  = 10;
  localparam int unsigned PosW      = 4;
  localparam int unsigned DistW     = 26;
  localparam int unsigned WeightW   = 17;

  localparam logic [PosW-1:0] PosErr0  = 4'd3;
  localparam logic [PosW-1:0] PosErr1  = 4'd4;
  localparam logic [PosW-1:0] PosErr2  = 4'd5;
  localparam logic [PosW-1:0] PosCheck = 4'd10;

  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiE    = 8'h45;
  localparam logic [7:0] AsciiR    = 8'h52;

  typedef logic [1:0] status_t;
  localparam status_t StatusOk      = 2'd0;
  localparam status_t StatusRange   = 2'd1;
  localparam status_t StatusCksum   = 2'd2;

  typedef logic [WeightW-1:0] weight_t;

  // Millimeter weight of the digit at a frame position; zero where no digit.
  function automatic weight_t digit_weight(input logic [PosW-1:0] pos);
    weight_t w;
    unique case (pos)
      4'd3:    w = 17'd100000;
      4'd4:    w = 17'd10000;
      4'd5:    w = 17'd1000;
      4'd7:    w = 17'd100;
      4'd8:    w = 17'd10;
      4'd9:    w = 17'd1;
      default: w = 17'd0;
    endcase
    return w;
  endfunction

endpackage

### rtl/core/laser_range_frame_parser_core.sv
// Top level: 11-byte rangefinder reply parser with checksum check and distance assembly.
// Takes one received byte per clock cycle with no stall of its own; in_ready drops only
// while a finished result sits in the output register and out_ready is low. Digit terms
// are multiplied by their constant weight and accumulated as each byte arrives, so the
// checksum byte (frame byte 10) only compares and loads the output register: its result
// appears on out_valid in the cycle after that byte's transfer. frame_start forces byte 0.
module laser_range_frame_parser_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_rx_byte,
  input  logic                             in_frame_start,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_frame_status,
  output logic signed [lrfp_pkg::DistW-1:0] out_distance_mm
);

  logic [lrfp_pkg::PosW-1:0]         pos_r, pos_nxt, pos_eff;
  logic [7:0]                        sum_r, sum_nxt, sum_eff;
  logic signed [lrfp_pkg::DistW-1:0] acc_r, acc_nxt, acc_eff;
  logic [7:0]                        b3_r, b4_r, b5_r;
  logic                              out_valid_r;
  lrfp_pkg::status_t                 status_r, status_nxt;
  logic signed [lrfp_pkg::DistW-1:0] dist_r, dist_nxt;

  logic                              in_fire, restart, at_check;
  logic signed [8:0]                 digit;
  logic signed [26:0]                term;
  lrfp_pkg::weight_t                 weight;
  logic [7:0]                        expect_sum;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_frame_status = status_r;
  assign out_distance_mm  = dist_r;

  assign restart  = in_frame_start || (pos_r > lrfp_pkg::PosCheck);
  assign pos_eff  = restart ? '0 : pos_r;
  assign sum_eff  = restart ? '0 : sum_r;
  assign acc_eff  = restart ? '0 : acc_r;
  assign at_check = (pos_eff == lrfp_pkg::PosCheck);

  assign weight = lrfp_pkg::digit_weight(pos_eff);
  assign digit  = $signed({1'b0, in_rx_byte}) - $signed({1'b0, lrfp_pkg::AsciiZero});
  assign term   = 27'(digit) * 27'($signed({1'b0, weight}));
  assign expect_sum = 8'(8'd0 - sum_eff);

  always_comb begin
    pos_nxt    = pos_eff + 4'd1;
    sum_nxt    = sum_eff + in_rx_byte;
    acc_nxt    = acc_eff + term[lrfp_pkg::DistW-1:0];
    status_nxt = lrfp_pkg::StatusOk;
    dist_nxt   = '0;
    if (at_check) begin
      pos_nxt = '0;
      sum_nxt = '0;
      acc_nxt = '0;
    end
    priority if (in_rx_byte != expect_sum) begin
      status_nxt = lrfp_pkg::StatusCksum;
    end else if (b3_r == lrfp_pkg::AsciiE && b4_r == lrfp_pkg::AsciiR &&
                 b5_r == lrfp_pkg::AsciiR) begin
      status_nxt = lrfp_pkg::StatusRange;
    end else begin
      dist_nxt = acc_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      sum_r       <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        pos_r <= pos_nxt;
        sum_r <= sum_nxt;
        acc_r <= acc_nxt;
      end
      if (in_fire && at_check) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (pos_eff == lrfp_pkg::PosErr0) b3_r <= in_rx_byte;
      if (pos_eff == lrfp_pkg::PosErr1) b4_r <= in_rx_byte;
      if (pos_eff == lrfp_pkg::PosErr2) b5_r <= in_rx_byte;
      if (at_check) begin
        status_r <= status_nxt;
        dist_r   <= dist_nxt;
      end
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= lrfp_pkg::PosCheck)
    else $error("frame position out of range");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && at_check |=> out_valid_r && pos_r == '0 && sum_r == '0 && acc_r == '0)
    else $error("checksum byte did not produce a result or clear the frame");

  a_no_result_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !at_check && !(out_valid_r && !out_ready) |=> !out_valid_r)
    else $error("result without checksum byte");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> status_r == lrfp_pkg::StatusOk || status_r == lrfp_pkg::StatusRange ||
                    status_r == lrfp_pkg::StatusCksum)
    else $error("invalid status code");

  a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != lrfp_pkg::StatusOk |-> dist_r == '0)
    else $error("distance not zero on error status");

endmodule

### test/laser_range_frame_parser_core_tb.sv
// Testbench: drives reply-frame bytes with random gaps and stalls, scored against a predictor.
module laser_range_frame_parser_core_tb;

  localparam int RandItems     = 1150;
  localparam int RxHoldCycles  = 200;
  localparam int WatchdogLimit = 5000;
  localparam int DigitBase     = 3;
  localparam logic signed [lrfp_pkg::DistW-1:0] MinMm = -26'sd5333328;
  localparam logic signed [lrfp_pkg::DistW-1:0] MaxMm = 26'sd22999977;

  typedef struct packed {
    lrfp_pkg::status_t                  status;
    logic signed [lrfp_pkg::DistW-1:0]  mm;
  } frame_result_t;

  typedef struct {
    logic [7:0]                        rx;
    logic                              st;
    bit                                typed;
    lrfp_pkg::status_t                 status;
    logic signed [lrfp_pkg::DistW-1:0] mm;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic in_frame_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_frame_status;
  logic signed [lrfp_pkg::DistW-1:0] out_distance_mm;

  laser_range_frame_parser_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_rx_byte(in_rx_byte), .in_frame_start(in_frame_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_frame_status(out_frame_status), .out_distance_mm(out_distance_mm)
  );

  always #10 clk = ~clk;

  // frame parser shadow state
  logic [3:0] fp_pos = '0;
  logic [7:0] fp_sum = '0;
  logic [7:0] fp_bytes [7];

  frame_result_t pending_results[$];
  int err_cnt = 0;
  int items_sent = 0;
  int n_ok = 0, n_range = 0, n_cksum = 0;
  int quiet_cycles = 0;
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  bit hold_req = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int digit_val(input int idx);
    return int'(fp_bytes[idx]) - int'(lrfp_pkg::AsciiZero);
  endfunction

  // Advance the shadow parser by one byte; returns 1 when the byte closes a frame.
  function automatic bit parse_byte(input logic [7:0] b, input logic st,
                                    output frame_result_t res);
    logic [3:0] p;
    logic [7:0] want;
    int acc;
    p = fp_pos;
    res.status = lrfp_pkg::StatusOk;
    res.mm = '0;
    if (st || p >= lrfp_pkg::FrameLen) begin
      p = '0;
      fp_sum = '0;
    end
    if (p < lrfp_pkg::CheckPos) begin
      fp_sum = fp_sum + b;
      if (p >= DigitBase) fp_bytes[p - DigitBase] = b;
      fp_pos = p + 4'd1;
      return 1'b0;
    end
    want = 8'(0 - fp_sum);
    if (b != want) begin
      res.status = lrfp_pkg::StatusCksum;
    end else if (fp_bytes[0] == lrfp_pkg::AsciiE && fp_bytes[1] == lrfp_pkg::AsciiR &&
                 fp_bytes[2] == lrfp_pkg::AsciiR) begin
      res.status = lrfp_pkg::StatusRange;
    end else begin
      acc = digit_val(0) * 100000 + digit_val(1) * 10000 + digit_val(2) * 1000 +
            digit_val(4) * 100 + digit_val(5) * 10 + digit_val(6);
      res.mm = acc[lrfp_pkg::DistW-1:0];
    end
    fp_pos = '0;
    fp_sum = '0;
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic st, input bit typed,
                           input lrfp_pkg::status_t ts,
                           input logic signed [lrfp_pkg::DistW-1:0] tmm);
    int gap;
    frame_result_t res;
    bit got;
    @(negedge clk);
    gap = tx_idle ? idle_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    in_frame_start <= st;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    got = parse_byte(b, st, res);
    if (typed) pending_results.push_back('{ts, tmm});
    else if (got) pending_results.push_back(res);
  endtask

  function automatic logic [7:0] digit_char();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return lrfp_pkg::AsciiZero + 8'($urandom_range(0, 9));
  endfunction

  // Mostly well-formed frames, some cut short, some raw noise.
  task automatic send_frame();
    logic [7:0] fb [11];
    logic [7:0] ck;
    int kind, len, i;
    bit st;
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      len = $urandom_range(1, 15);
      for (i = 0; i < len; i++)
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, 1'b0,
                  lrfp_pkg::StatusOk, '0);
      return;
    end
    for (i = 0; i < 3; i++) fb[i] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 6) == 0) begin
      fb[3] = lrfp_pkg::AsciiE;
      fb[4] = lrfp_pkg::AsciiR;
      fb[5] = lrfp_pkg::AsciiR;
      if ($urandom_range(0, 4) == 0) fb[$urandom_range(3, 5)] = 8'($urandom_range(0, 255));
    end else begin
      for (i = 3; i < 6; i++) fb[i] = digit_char();
    end
    fb[6] = ($urandom_range(0, 4) != 0) ? 8'h2e : 8'($urandom_range(0, 255));
    for (i = 7; i < 10; i++) fb[i] = digit_char();
    ck = '0;
    for (i = 0; i < 10; i++) ck = ck + fb[i];
    fb[10] = 8'(0 - ck);
    if ($urandom_range(0, 6) == 0) fb[10] = fb[10] ^ 8'($urandom_range(1, 255));
    len = (kind >= 80) ? $urandom_range(1, 10) : 11;
    st = $urandom_range(0, 3) != 0;
    for (i = 0; i < len; i++) send_byte(fb[i], st && i == 0, 1'b0, lrfp_pkg::StatusOk, '0);
  endtask

  // result side
  always begin
    @(negedge clk);
    if (hold_req) begin
      int held;
      hold_req = 1'b0;
      out_ready <= 1'b0;
      held = 1;
      while (held < RxHoldCycles) begin
        @(negedge clk);
        held++;
      end
    end else begin
      int stall;
      stall = rx_idle ? idle_len() : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    frame_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with none expected: status %0d mm %0d",
                                  out_frame_status, out_distance_mm));
      end else begin
        exp_res = pending_results.pop_front();
        if (out_frame_status !== exp_res.status)
          report_mismatch($sformatf("frame_status %0d, expected %0d",
                                    out_frame_status, exp_res.status));
        if (out_distance_mm !== exp_res.mm)
          report_mismatch($sformatf("distance_mm %0d, expected %0d",
                                    out_distance_mm, exp_res.mm));
        case (exp_res.status)
          lrfp_pkg::StatusOk:    n_ok++;
          lrfp_pkg::StatusRange: n_range++;
          default:               n_cksum++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("timeout: no transfer for %0d cycles, %0d results pending",
               quiet_cycles, pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    stim_row_t dir_rows[$];
    int i, phase;
    bit hold_done;
    hold_done = 1'b0;

    // all 0x00 digits: most negative distance
    for (i = 0; i < 11; i++)
      dir_rows.push_back('{8'h00, i == 0, i == 10, lrfp_pkg::StatusOk, MinMm});
    // free running into 0xFF bytes, realigned where byte 10 would fall, then a frame of 0xFF data bytes
    for (i = 0; i < 10; i++) dir_rows.push_back('{8'hFF, 1'b0, 1'b0, lrfp_pkg::StatusOk, '0});
    dir_rows.push_back('{8'hFF, 1'b1, 1'b0, lrfp_pkg::StatusOk, '0});
    for (i = 0; i < 9; i++) dir_rows.push_back('{8'hFF, 1'b0, 1'b0, lrfp_pkg::StatusOk, '0});
    dir_rows.push_back('{8'h0A, 1'b0, 1'b1, lrfp_pkg::StatusOk, MaxMm});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k])
      send_byte(dir_rows[k].rx, dir_rows[k].st, dir_rows[k].typed,
                dir_rows[k].status, dir_rows[k].mm);

    while (items_sent < dir_rows.size() + RandItems) begin
      phase = (items_sent - dir_rows.size()) * 4 / RandItems;
      tx_idle = (phase == 1 || phase == 2);
      rx_idle = (phase >= 2);
      if (phase == 1 && !hold_done) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      send_frame();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    rx_idle = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("sent %0d bytes incl. realignment, free running and noise; receiver held %0d",
             items_sent, RxHoldCycles);
    $display("frames scored: %0d distance, %0d out of range, %0d checksum error",
             n_ok, n_range, n_cksum);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
